### rtl/core/lsq_pkg.sv
// shared constants and permutation tables for the least-squares solver
`timescale 1ns / 1ps

package lsq_pkg;

	// defaults for the top-level parameters
	localparam int DEF_MAX_FEATURES = 4;
	localparam int DEF_MAX_SAMPLES  = 65536;
	localparam int DEF_SAMPLE_BITS  = 16;

	// fixed field and arithmetic widths
	localparam int IN_W      = 16;
	localparam int SUM_W     = 48;
	localparam int COEF_W    = 48;
	localparam int BIG_W     = 256;
	localparam int FRAC_BITS = 24;
	localparam int NPERM     = 24;

	typedef logic [BIG_W-1:0] big_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	// column picked for a row by each of the 24 permutations of four columns
	function automatic logic [7:0] perm_cols(input logic [4:0] p);
		logic [7:0] v;
		unique case (p)
			5'd0:  v = {2'd3, 2'd2, 2'd1, 2'd0};
			5'd1:  v = {2'd2, 2'd3, 2'd1, 2'd0};
			5'd2:  v = {2'd3, 2'd1, 2'd2, 2'd0};
			5'd3:  v = {2'd1, 2'd3, 2'd2, 2'd0};
			5'd4:  v = {2'd2, 2'd1, 2'd3, 2'd0};
			5'd5:  v = {2'd1, 2'd2, 2'd3, 2'd0};
			5'd6:  v = {2'd3, 2'd2, 2'd0, 2'd1};
			5'd7:  v = {2'd2, 2'd3, 2'd0, 2'd1};
			5'd8:  v = {2'd3, 2'd0, 2'd2, 2'd1};
			5'd9:  v = {2'd0, 2'd3, 2'd2, 2'd1};
			5'd10: v = {2'd2, 2'd0, 2'd3, 2'd1};
			5'd11: v = {2'd0, 2'd2, 2'd3, 2'd1};
			5'd12: v = {2'd3, 2'd1, 2'd0, 2'd2};
			5'd13: v = {2'd1, 2'd3, 2'd0, 2'd2};
			5'd14: v = {2'd3, 2'd0, 2'd1, 2'd2};
			5'd15: v = {2'd0, 2'd3, 2'd1, 2'd2};
			5'd16: v = {2'd1, 2'd0, 2'd3, 2'd2};
			5'd17: v = {2'd0, 2'd1, 2'd3, 2'd2};
			5'd18: v = {2'd2, 2'd1, 2'd0, 2'd3};
			5'd19: v = {2'd1, 2'd2, 2'd0, 2'd3};
			5'd20: v = {2'd2, 2'd0, 2'd1, 2'd3};
			5'd21: v = {2'd0, 2'd2, 2'd1, 2'd3};
			5'd22: v = {2'd1, 2'd0, 2'd2, 2'd3};
			5'd23: v = {2'd0, 2'd1, 2'd2, 2'd3};
			default: v = 8'd0;
		endcase
		return v;
	endfunction

	// odd permutations carry a minus sign
	localparam logic [NPERM-1:0] PERM_ODD = 24'b0110_0110_0110_0110_0110_0110;

	function automatic logic [1:0] perm_col(input logic [4:0] p, input logic [1:0] row);
		logic [7:0] v;
		v = perm_cols(p);
		return v[2*row +: 2];
	endfunction

endpackage

### rtl/core/least_squares_normal_solver_top.sv
// least-squares fit: gram accumulation and exact cramer-rule solve
//
// channel  dir  handshake            word
// in       in   in_valid / in_stall  feature_0..3, target, last_sample
// out      out  out_valid / out_stall coef_index, coefficient, singular,
//                                     samples_dropped, last_coef
// cfg      in   cfg_we               cfg_wdata (features_used)
//
// each row runs 20 multiply-accumulates on one 16x16 multiplier.
// a solve takes up to 5 determinants of 24 terms x 4 bit-serial
// multiplies, plus a restoring division per coefficient; a singular
// run skips the numerators.
// reset clears the sums, sample count and drop flag, features_used to 4.
// a coefficient waiting in the output register does not hold the next
// determinant; the sequencer waits only when a new coefficient is ready.
`timescale 1ns / 1ps

module least_squares_normal_solver_top
	import lsq_pkg::*;
#(
	parameter int MAX_FEATURES = DEF_MAX_FEATURES,
	parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES,
	parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [2:0]               cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [IN_W-1:0]   feature_0,
	input  logic signed [IN_W-1:0]   feature_1,
	input  logic signed [IN_W-1:0]   feature_2,
	input  logic signed [IN_W-1:0]   feature_3,
	input  logic signed [IN_W-1:0]   target,
	input  logic                     last_sample,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               coef_index,
	output logic signed [COEF_W-1:0] coefficient,
	output logic                     singular,
	output logic                     samples_dropped,
	output logic                     last_coef
);

	localparam int NCOL    = (MAX_FEATURES < 4) ? MAX_FEATURES : 4;
	localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
	localparam int SH      = IN_W - SAMPLE_BITS;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_ACC    = 4'd1;
	localparam logic [3:0] S_SOLVE  = 4'd2;
	localparam logic [3:0] S_DSTART = 4'd3;
	localparam logic [3:0] S_TSTART = 4'd4;
	localparam logic [3:0] S_FLOAD  = 4'd5;
	localparam logic [3:0] S_MUL    = 4'd6;
	localparam logic [3:0] S_TADD   = 4'd7;
	localparam logic [3:0] S_DDONE  = 4'd8;
	localparam logic [3:0] S_DIV    = 4'd9;
	localparam logic [3:0] S_EMIT   = 4'd10;

	logic [3:0] state_q;

	logic [2:0]             fu_q;
	sum_t                   gram_q [4][4];
	sum_t                   mom_q  [4];
	logic [CNT_W-1:0]       cnt_q;
	logic                   ovf_q;

	logic signed [IN_W-1:0] x_q [4];
	logic signed [IN_W-1:0] y_q;
	logic                   last_q;
	logic [4:0]             k_q;

	logic [2:0]             n_q;
	logic                   numer_q;
	logic [1:0]             ci_q;
	logic                   sing_q;

	logic [4:0]             perm_q;
	logic [1:0]             step_q;
	logic [5:0]             bit_q;
	big_t                   term_q;
	big_t                   prod_q;
	logic [SUM_W-1:0]       mul_q;
	logic                   tneg_q;
	big_t                   det_q;

	big_t                   den_q;
	logic                   den_neg_q;
	big_t                   num_q;
	big_t                   rem_q;
	logic [COEF_W-1:0]      quo_q;
	logic                   sticky_q;
	logic                   neg_q;
	logic [7:0]             dcnt_q;

	logic                   out_valid_q;
	logic [1:0]             out_idx_q;
	logic signed [COEF_W-1:0] out_coef_q;
	logic                   out_sing_q;
	logic                   out_drop_q;
	logic                   out_last_q;

	// sign-extend inputs from their low SAMPLE_BITS bits
	logic signed [IN_W-1:0] xs [4];
	logic signed [IN_W-1:0] ys;
	logic signed [IN_W-1:0] fin [4];
	assign fin[0] = feature_0;
	assign fin[1] = feature_1;
	assign fin[2] = feature_2;
	assign fin[3] = feature_3;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			xs[i] = (fin[i] <<< SH) >>> SH;
		end
		ys = (target <<< SH) >>> SH;
	end

	// accumulation product on the shared multiplier
	logic [1:0]                 acc_r;
	logic [1:0]                 acc_c;
	logic signed [IN_W-1:0]     mul_b;
	logic signed [2*IN_W-1:0]   acc_prod;
	assign acc_r    = k_q[4] ? k_q[1:0] : k_q[3:2];
	assign acc_c    = k_q[1:0];
	assign mul_b    = k_q[4] ? y_q : x_q[acc_c];
	assign acc_prod = x_q[acc_r] * mul_b;

	// matrix entry for the current factor: moments in the numerator column, identity outside the fit
	logic [1:0] ent_c;
	sum_t       ent;
	logic [SUM_W-1:0] ent_mag;
	assign ent_c = perm_col(perm_q, step_q);

	always_comb begin
		if ({1'b0, step_q} >= n_q || {1'b0, ent_c} >= n_q) begin
			ent = (step_q == ent_c) ? sum_t'(1) : sum_t'(0);
		end else if (numer_q && ent_c == ci_q) begin
			ent = mom_q[step_q];
		end else begin
			ent = gram_q[step_q][ent_c];
		end
		ent_mag = ent[SUM_W-1] ? SUM_W'(-ent) : SUM_W'(ent);
	end

	// wide adders for shift-add multiply, determinant sum and division
	big_t   mul_next;
	logic   tsgn;
	big_t   det_next;
	big_t   det_mag;
	logic [BIG_W:0] rem_sh;
	logic [BIG_W:0] rem_diff;
	assign mul_next = {prod_q[BIG_W-2:0], 1'b0} + (mul_q[SUM_W-1] ? term_q : '0);
	assign tsgn     = tneg_q ^ PERM_ODD[perm_q];
	assign det_next = det_q + (term_q ^ {BIG_W{tsgn}}) + BIG_W'(tsgn);
	assign det_mag  = det_q[BIG_W-1] ? (~det_q + BIG_W'(1)) : det_q;
	assign rem_sh   = {rem_q, num_q[BIG_W-1]};
	assign rem_diff = rem_sh - {1'b0, den_q};

	// final coefficient: zero when singular, else saturate and restore sign
	logic signed [COEF_W-1:0] coef_val;
	always_comb begin
		if (sing_q) begin
			coef_val = '0;
		end else if (sticky_q || quo_q[COEF_W-1]) begin
			coef_val = neg_q ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
		end else begin
			coef_val = neg_q ? -$signed(quo_q) : $signed(quo_q);
		end
	end

	logic out_free;
	logic in_acc;
	assign out_free = !out_valid_q || !out_stall;
	assign in_acc   = in_valid && !in_stall;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fu_q <= 3'd4;
		end else if (cfg_we) begin
			fu_q <= cfg_wdata;
		end
	end

	// sequencer, accumulators and solve datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			for (int r = 0; r < 4; r++) begin
				mom_q[r] <= '0;
				for (int c = 0; c < 4; c++) begin
					gram_q[r][c] <= '0;
				end
			end
			out_valid_q <= 1'b0;
		end else begin
			// output register: load a new word or drop a taken one
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						for (int i = 0; i < 4; i++) begin
							x_q[i] <= xs[i];
						end
						y_q    <= ys;
						last_q <= last_sample;
						k_q    <= '0;
						if (cnt_q >= CNT_W'(MAX_SAMPLES)) begin
							ovf_q   <= 1'b1;
							state_q <= last_sample ? S_SOLVE : S_IDLE;
						end else begin
							cnt_q   <= cnt_q + CNT_W'(1);
							state_q <= S_ACC;
						end
					end
				end
				S_ACC: begin
					if (k_q[4]) begin
						if (32'(acc_r) < NCOL) begin
							mom_q[acc_r] <= mom_q[acc_r] + SUM_W'(acc_prod);
						end
					end else if (32'(acc_r) < NCOL && 32'(acc_c) < NCOL) begin
						gram_q[acc_r][acc_c] <= gram_q[acc_r][acc_c] + SUM_W'(acc_prod);
					end
					k_q <= k_q + 5'd1;
					if (k_q == 5'd19) begin
						state_q <= last_q ? S_SOLVE : S_IDLE;
					end
				end
				S_SOLVE: begin
					if (fu_q == 3'd0) begin
						n_q <= 3'd1;
					end else if (32'(fu_q) > NCOL) begin
						n_q <= 3'(NCOL);
					end else begin
						n_q <= fu_q;
					end
					numer_q <= 1'b0;
					sing_q  <= 1'b0;
					ci_q    <= '0;
					state_q <= S_DSTART;
				end
				S_DSTART: begin
					det_q   <= '0;
					perm_q  <= '0;
					state_q <= S_TSTART;
				end
				S_TSTART: begin
					term_q  <= BIG_W'(1);
					tneg_q  <= 1'b0;
					step_q  <= '0;
					state_q <= S_FLOAD;
				end
				S_FLOAD: begin
					mul_q   <= ent_mag;
					tneg_q  <= tneg_q ^ ent[SUM_W-1];
					prod_q  <= '0;
					bit_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q <= mul_next;
					mul_q  <= {mul_q[SUM_W-2:0], 1'b0};
					bit_q  <= bit_q + 6'd1;
					if (bit_q == 6'(SUM_W - 1)) begin
						term_q <= mul_next;
						if (step_q == 2'd3) begin
							state_q <= S_TADD;
						end else begin
							step_q  <= step_q + 2'd1;
							state_q <= S_FLOAD;
						end
					end
				end
				S_TADD: begin
					det_q <= det_next;
					if (perm_q == 5'(NPERM - 1)) begin
						state_q <= S_DDONE;
					end else begin
						perm_q  <= perm_q + 5'd1;
						state_q <= S_TSTART;
					end
				end
				S_DDONE: begin
					if (!numer_q) begin
						den_q     <= det_mag;
						den_neg_q <= det_q[BIG_W-1];
						if (det_q == '0) begin
							sing_q  <= 1'b1;
							state_q <= S_EMIT;
						end else begin
							numer_q <= 1'b1;
							state_q <= S_DSTART;
						end
					end else begin
						num_q    <= det_mag << FRAC_BITS;
						neg_q    <= det_q[BIG_W-1] ^ den_neg_q;
						rem_q    <= '0;
						quo_q    <= '0;
						sticky_q <= 1'b0;
						dcnt_q   <= '0;
						state_q  <= S_DIV;
					end
				end
				S_DIV: begin
					num_q    <= {num_q[BIG_W-2:0], 1'b0};
					sticky_q <= sticky_q | quo_q[COEF_W-1];
					if (!rem_diff[BIG_W]) begin
						rem_q <= rem_diff[BIG_W-1:0];
						quo_q <= {quo_q[COEF_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[BIG_W-1:0];
						quo_q <= {quo_q[COEF_W-2:0], 1'b0};
					end
					dcnt_q <= dcnt_q + 8'd1;
					if (dcnt_q == 8'(BIG_W - 1)) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_idx_q   <= ci_q;
						out_coef_q  <= coef_val;
						out_sing_q  <= sing_q;
						out_drop_q  <= ovf_q;
						out_last_q  <= ({1'b0, ci_q} == n_q - 3'd1);
						if ({1'b0, ci_q} == n_q - 3'd1) begin
							cnt_q <= '0;
							ovf_q <= 1'b0;
							for (int r = 0; r < 4; r++) begin
								mom_q[r] <= '0;
								for (int c = 0; c < 4; c++) begin
									gram_q[r][c] <= '0;
								end
							end
							state_q <= S_IDLE;
						end else begin
							ci_q    <= ci_q + 2'd1;
							state_q <= sing_q ? S_EMIT : S_DSTART;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall        = (state_q != S_IDLE);
	assign out_valid       = out_valid_q;
	assign coef_index      = out_idx_q;
	assign coefficient     = out_coef_q;
	assign singular        = out_sing_q;
	assign samples_dropped = out_drop_q;
	assign last_coef       = out_last_q;

	// a singular word carries a zero coefficient
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_sing_q |-> out_coef_q == '0)
		else $error("singular word with nonzero coefficient");

	// the last word of a run names the last feature in use
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_last_q |-> {1'b0, out_idx_q} == n_q - 3'd1)
		else $error("last word at wrong feature index");

	// a word is never loaded over one still waiting to be taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(out_coef_q))
		else $error("waiting word overwritten");

	// leaving a solve clears the sample count
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && $past(state_q) == S_EMIT |-> cnt_q == '0)
		else $error("sample count not cleared after solve");

endmodule
